[sv/rsc_pkg.sv]
package rsc_pkg;

  // Fixed widths of the configuration registers and of the result fields.
  localparam int CL_W       = 4;
  localparam int NP_W       = 3;
  localparam int POLY_W     = 9;
  localparam int NUM_GEN    = 4;
  localparam int POLYS_W    = NUM_GEN * POLY_W;
  localparam int PAR_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = POLYS_W;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CODE_LEN          = 3'd0,
    CFG_NUM_PARITY        = 3'd1,
    CFG_FEEDBACK_POLY     = 3'd2,
    CFG_PARITY_POLYS      = 3'd3,
    CFG_TERMINATE_ENABLE  = 3'd4,
    CFG_SYSTEMATIC_ENABLE = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [CL_W-1:0]    code_len;
    logic [NP_W-1:0]    num_parity;
    logic [POLY_W-1:0]  feedback_poly;
    logic [POLYS_W-1:0] parity_polys;
    logic               terminate_enable;
    logic               systematic_enable;
  } cfg_t;

  typedef struct packed {
    logic             last;
    logic             is_tail;
    logic [PAR_W-1:0] parity_bits;
    logic             sys_bit;
  } result_t;

endpackage

[sv/recursive_convolutional_encoder_top.sv]
// Recursive systematic convolutional encoder. Each input beat carries one
// source bit (tdata bit 0) and a block end mark (tlast); each output beat
// carries the systematic bit and up to four parity bits, with tuser set on
// termination tail beats and tlast on the final beat of a block. A source
// beat is taken every cycle while the two-entry output buffer has room, so
// the encoder sustains one beat per clock. When a block ends with
// termination enabled, the encoder holds off input while it emits the
// code length minus one tail beats that drive the state back to zero.
// Configuration is written through a simple write port and must
// only change while no beats are in flight.
module recursive_convolutional_encoder_top #(
  parameter int MAX_CONSTRAINT = 9,
  parameter int MAX_PARITY     = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rsc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rsc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Bit 0: source_bit; bits 7:1 unused.
  input  logic [7:0]                        s_axis_tdata,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // Bit 0: sys_bit; bits 4:1: parity_bits; bits 7:5 zero.
  output logic [7:0]                        m_axis_tdata,
  // Bit 0: is_tail.
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast
);

  localparam int SW = MAX_CONSTRAINT - 1;
  localparam int MW = $clog2(MAX_CONSTRAINT);

  rsc_pkg::cfg_t     cfg_q;
  logic [SW-1:0]     state_q, state_d;
  logic [MW-1:0]     tail_cnt_q, tail_cnt_d;

  logic              buf_ready;
  logic              in_tail;
  logic              accept;
  logic              tail_go;
  logic              push;
  logic [SW-1:0]     step_state;
  logic              step_sys;
  logic [rsc_pkg::PAR_W-1:0] step_par;
  logic [MW-1:0]     reg_bits;
  rsc_pkg::result_t  res;
  rsc_pkg::result_t  buf_data;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.code_len          <= rsc_pkg::CL_W'(3);
      cfg_q.num_parity        <= rsc_pkg::NP_W'(2);
      cfg_q.feedback_poly     <= '0;
      cfg_q.parity_polys      <= '0;
      cfg_q.terminate_enable  <= 1'b1;
      cfg_q.systematic_enable <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rsc_pkg::CFG_CODE_LEN: begin
          cfg_q.code_len <= cfg_data_i[rsc_pkg::CL_W-1:0];
        end
        rsc_pkg::CFG_NUM_PARITY: begin
          cfg_q.num_parity <= cfg_data_i[rsc_pkg::NP_W-1:0];
        end
        rsc_pkg::CFG_FEEDBACK_POLY: begin
          cfg_q.feedback_poly <= cfg_data_i[rsc_pkg::POLY_W-1:0];
        end
        rsc_pkg::CFG_PARITY_POLYS: begin
          cfg_q.parity_polys <= cfg_data_i[rsc_pkg::POLYS_W-1:0];
        end
        rsc_pkg::CFG_TERMINATE_ENABLE: begin
          cfg_q.terminate_enable <= cfg_data_i[0];
        end
        rsc_pkg::CFG_SYSTEMATIC_ENABLE: begin
          cfg_q.systematic_enable <= cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  // A nonzero tail count means tail beats are still owed for this block.
  assign in_tail       = (tail_cnt_q != '0);
  assign s_axis_tready = buf_ready & ~in_tail;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign tail_go       = in_tail & buf_ready;
  assign push          = accept | tail_go;

  // One trellis step, either for the source beat or for a tail beat.
  rsc_step #(
    .MAX_CONSTRAINT (MAX_CONSTRAINT),
    .MAX_PARITY     (MAX_PARITY)
  ) u_step (
    .cfg_i      (cfg_q),
    .state_i    (state_q),
    .src_i      (s_axis_tdata[0]),
    .tail_i     (in_tail),
    .state_o    (step_state),
    .sys_o      (step_sys),
    .parity_o   (step_par),
    .reg_bits_o (reg_bits)
  );

  always_comb begin
    res.sys_bit     = step_sys;
    res.parity_bits = step_par;
    res.is_tail     = in_tail;
    if (in_tail) begin
      res.last = (tail_cnt_q == MW'(1));
    end else begin
      res.last = s_axis_tlast & ~cfg_q.terminate_enable;
    end
  end

  // The state returns to zero at every block end, after the tail if any.
  always_comb begin
    state_d    = state_q;
    tail_cnt_d = tail_cnt_q;
    if (accept) begin
      if (!s_axis_tlast) begin
        state_d = step_state;
      end else if (cfg_q.terminate_enable) begin
        state_d    = step_state;
        tail_cnt_d = reg_bits;
      end else begin
        state_d = '0;
      end
    end else if (tail_go) begin
      tail_cnt_d = tail_cnt_q - MW'(1);
      state_d    = (tail_cnt_q == MW'(1)) ? '0 : step_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= '0;
      tail_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      tail_cnt_q <= tail_cnt_d;
    end
  end

  // Result buffer: decouples the output handshake from input acceptance.
  rsc_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_i      (res),
    .ready_o     (buf_ready),
    .valid_o     (m_axis_tvalid),
    .data_o      (buf_data),
    .pop_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {3'b000, buf_data.parity_bits, buf_data.sys_bit};
  assign m_axis_tuser = buf_data.is_tail;
  assign m_axis_tlast = buf_data.last;

endmodule

[sv/rsc_step.sv]
module rsc_step #(
  parameter int MAX_CONSTRAINT = 9,
  parameter int MAX_PARITY     = 4
) (
  input  rsc_pkg::cfg_t                      cfg_i,
  input  logic [MAX_CONSTRAINT-2:0]          state_i,
  input  logic                               src_i,
  input  logic                               tail_i,
  output logic [MAX_CONSTRAINT-2:0]          state_o,
  output logic                               sys_o,
  output logic [rsc_pkg::PAR_W-1:0]          parity_o,
  output logic [$clog2(MAX_CONSTRAINT)-1:0]  reg_bits_o
);

  localparam int SW = MAX_CONSTRAINT - 1;
  localparam int EW = MAX_CONSTRAINT;
  localparam int MW = $clog2(MAX_CONSTRAINT);

  logic [5:0]                      cl_ext;
  logic [MW-1:0]                   m;
  logic [SW-1:0]                   mask;
  logic [SW-1:0]                   s;
  logic [SW+rsc_pkg::POLY_W-1:0]   fb_poly_ext;
  logic                            fb;
  logic                            top_bit;
  logic [EW-1:0]                   ext;

  // Saturate the constraint length and derive the register length.
  always_comb begin
    cl_ext = 6'(cfg_i.code_len);
    if (cl_ext > 6'(MAX_CONSTRAINT)) begin
      m = MW'(MAX_CONSTRAINT - 1);
    end else if (cl_ext < 6'd2) begin
      m = MW'(1);
    end else begin
      m = MW'(cl_ext - 6'd1);
    end
  end

  always_comb begin
    for (int j = 0; j < SW; j++) begin
      mask[j] = (32'(j) < 32'(m));
    end
  end

  assign fb_poly_ext = (SW + rsc_pkg::POLY_W)'(cfg_i.feedback_poly);
  assign s           = state_i & mask;
  assign fb          = ^(s & fb_poly_ext[SW-1:0] & mask);

  // A tail step feeds the feedback bit back in, so a zero enters at the top.
  assign top_bit = tail_i ? 1'b0 : (fb ^ src_i);

  always_comb begin
    ext = EW'(s);
    for (int j = 0; j < EW; j++) begin
      if (32'(j) == 32'(m)) begin
        ext[j] = top_bit;
      end
    end
  end

  for (genvar i = 0; i < rsc_pkg::PAR_W; i++) begin : g_gen
    logic [EW+rsc_pkg::POLY_W-1:0] g_ext;
    logic                          en;
    assign g_ext = (EW + rsc_pkg::POLY_W)'(
                     cfg_i.parity_polys[i*rsc_pkg::POLY_W +: rsc_pkg::POLY_W]);
    assign en    = (i == 0) ||
                   ((32'(cfg_i.num_parity) > i) && (i < MAX_PARITY));
    assign parity_o[i] = en & (^(ext & g_ext[EW-1:0]));
  end

  assign state_o    = ext[EW-1:1];
  assign sys_o      = cfg_i.systematic_enable & (tail_i ? fb : src_i);
  assign reg_bits_o = m;

endmodule

[sv/rsc_obuf.sv]
module rsc_obuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rsc_pkg::result_t  data_i,
  output logic              ready_o,
  output logic              valid_o,
  output rsc_pkg::result_t  data_o,
  input  logic              pop_ready_i
);

  rsc_pkg::result_t mem_q [2];
  logic             wr_q, wr_d;
  logic             rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];
  assign pop     = valid_o & pop_ready_i;

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

[sv/rsc_checker.sv]
module rsc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled output beat holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  // Tail beats come back to back: a taken non-final tail beat is followed
  // right away by another tail beat.
  a_tail_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tuser && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tuser)
    else $error("tail run broken");

  // No source beat is taken while a block's tail is still being delivered.
  a_tail_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser && !m_axis_tlast |-> !s_axis_tready)
    else $error("input ready during tail");

  // The unused high bits of the output data stay zero.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:5] == 3'b000))
    else $error("output padding not zero");

endmodule

bind recursive_convolutional_encoder_top rsc_checker u_rsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

[verif/tb_recursive_convolutional_encoder_top.sv]
// Scoreboard for the recursive convolutional encoder. It keeps its own copy of
// the configuration and of the shift register, turns every accepted source beat
// into the coded beats it must produce and checks the output beats in order.
class rsc_scoreboard;
  localparam int MAX_CL = 9;
  localparam int MAX_GEN = 4;

  bit [rsc_pkg::CL_W-1:0]    cl;
  bit [rsc_pkg::NP_W-1:0]    np;
  bit [rsc_pkg::POLY_W-1:0]  fb_poly;
  bit [rsc_pkg::POLYS_W-1:0] gen_polys;
  bit                        term_en;
  bit                        sys_en;
  bit [7:0]                  shift_state;
  rsc_pkg::result_t          pending_codes[$];
  int unsigned               errors;

  function new();
    cl          = 4'd3;
    np          = 3'd2;
    fb_poly     = '0;
    gen_polys   = '0;
    term_en     = 1'b1;
    sys_en      = 1'b1;
    shift_state = '0;
    errors      = 0;
  endfunction

  function void write_reg(logic [rsc_pkg::CFG_IDX_W-1:0] idx,
                          logic [rsc_pkg::CFG_DATA_W-1:0] value);
    case (idx)
      rsc_pkg::CFG_CODE_LEN:          cl        = value[rsc_pkg::CL_W-1:0];
      rsc_pkg::CFG_NUM_PARITY:        np        = value[rsc_pkg::NP_W-1:0];
      rsc_pkg::CFG_FEEDBACK_POLY:     fb_poly   = value[rsc_pkg::POLY_W-1:0];
      rsc_pkg::CFG_PARITY_POLYS:      gen_polys = value[rsc_pkg::POLYS_W-1:0];
      rsc_pkg::CFG_TERMINATE_ENABLE:  term_en   = value[0];
      rsc_pkg::CFG_SYSTEMATIC_ENABLE: sys_en    = value[0];
      default: ;
    endcase
  endfunction

  // Register depth after the constraint length is clamped into its legal range.
  function int unsigned reg_bits();
    int unsigned c;
    c = cl;
    if (c < 2) c = 2;
    if (c > MAX_CL) c = MAX_CL;
    return c - 1;
  endfunction

  function int unsigned gen_count();
    int unsigned n;
    n = np;
    if (n < 1) n = 1;
    if (n > MAX_GEN) n = MAX_GEN;
    return n;
  endfunction

  function bit feedback_bit(bit [7:0] s, int unsigned m);
    return ^(s & fb_poly[7:0] & (8'hFF >> (8 - m)));
  endfunction

  // One trellis step: returns the next register value and the parity nibble.
  function bit [7:0] trellis_step(bit [7:0] s, bit din, int unsigned m,
                                  output bit [3:0] par);
    bit [8:0]    ext;
    bit [8:0]    g;
    int unsigned n;
    ext = {1'b0, s};
    ext[m] = feedback_bit(s, m) ^ din;
    n = gen_count();
    par = '0;
    for (int i = 0; i < n; i++) begin
      g = gen_polys[9*i +: 9] & (9'h1FF >> (8 - m));
      par[i] = ^(ext & g);
    end
    return ext[8:1];
  endfunction

  function void note_source_beat(bit src, bit blk_end);
    int unsigned      m;
    bit [7:0]         s;
    bit [3:0]         par;
    bit               tail_in;
    rsc_pkg::result_t code;
    m = reg_bits();
    s = shift_state & (8'hFF >> (8 - m));
    s = trellis_step(s, src, m, par);
    code.sys_bit     = sys_en ? src : 1'b0;
    code.parity_bits = par;
    code.is_tail     = 1'b0;
    code.last        = blk_end && !term_en;
    pending_codes = {pending_codes, code};
    if (!blk_end) begin
      shift_state = s;
      return;
    end
    if (term_en) begin
      for (int t = 0; t < m; t++) begin
        tail_in = feedback_bit(s, m);
        s = trellis_step(s, tail_in, m, par);
        code.sys_bit     = sys_en ? tail_in : 1'b0;
        code.parity_bits = par;
        code.is_tail     = 1'b1;
        code.last        = (t + 1 == m);
        pending_codes = {pending_codes, code};
      end
    end
    shift_state = '0;
  endfunction

  function int unsigned pending();
    return pending_codes.size();
  endfunction

  function void compare_field(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  function void check_coded_beat(rsc_pkg::result_t got);
    rsc_pkg::result_t want;
    if (pending_codes.size() == 0) begin
      errors++;
      $display("%0t: beat expected none actual %h", $time, got);
      return;
    end
    want = pending_codes.pop_front();
    compare_field("sys_bit", 4'(want.sys_bit), 4'(got.sys_bit));
    compare_field("parity_bits", want.parity_bits, got.parity_bits);
    compare_field("is_tail", 4'(want.is_tail), 4'(got.is_tail));
    compare_field("last", 4'(want.last), 4'(got.last));
  endfunction

  function void close_out();
    if (pending_codes.size() != 0) begin
      $display("%0t: beats expected %0d more actual 0", $time, pending_codes.size());
      errors += pending_codes.size();
    end
  endfunction
endclass

module tb_recursive_convolutional_encoder_top;

  // Random traffic is split into phases; the configuration changes between them.
  localparam int RANDOM_PHASES  = 8;
  // Cycles without any accepted beat before the run is declared hung. The
  // slowest legal stretch is a configuration pass or a stall burst, well below.
  localparam int WATCHDOG_LIMIT = 2000;
  // Quiet cycles after the last coded beat before a register write.
  localparam int SETTLE_CYCLES  = 4;
  // Cycles watched at the end for stray output beats.
  localparam int DRAIN_CYCLES   = 32;
  // Write indexes past the register list; the block must ignore them.
  localparam logic [rsc_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [rsc_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [rsc_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [rsc_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [7:0]                     s_axis_tdata;
  logic                           s_axis_tlast;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [7:0]                     m_axis_tdata;
  logic                           m_axis_tuser;
  logic                           m_axis_tlast;

  rsc_scoreboard sb = new();

  // Idling switches for the two sides, changed from phase to phase.
  bit          src_idle_on;
  bit          sink_idle_on;
  int unsigned stall_left;
  int unsigned quiet_cycles = 0;

  recursive_convolutional_encoder_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // A register write holds the enable high for a single cycle and drops it again,
  // so back-to-back writes never raise and drop the enable in one time step.
  // The scoreboard's copy of the register is updated as the write is driven.
  task automatic write_reg(input logic [rsc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rsc_pkg::CFG_DATA_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    sb.write_reg(idx, value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_encoder(input logic [rsc_pkg::CL_W-1:0] cl,
                                 input logic [rsc_pkg::NP_W-1:0] np,
                                 input logic [rsc_pkg::POLY_W-1:0] fb,
                                 input logic [rsc_pkg::POLYS_W-1:0] polys,
                                 input logic term, input logic sys);
    write_reg(rsc_pkg::CFG_CODE_LEN, rsc_pkg::CFG_DATA_W'(cl));
    write_reg(rsc_pkg::CFG_NUM_PARITY, rsc_pkg::CFG_DATA_W'(np));
    write_reg(rsc_pkg::CFG_FEEDBACK_POLY, rsc_pkg::CFG_DATA_W'(fb));
    write_reg(rsc_pkg::CFG_PARITY_POLYS, rsc_pkg::CFG_DATA_W'(polys));
    write_reg(rsc_pkg::CFG_TERMINATE_ENABLE, rsc_pkg::CFG_DATA_W'(term));
    write_reg(rsc_pkg::CFG_SYSTEMATIC_ENABLE, rsc_pkg::CFG_DATA_W'(sys));
  endtask

  // Offers one source beat and returns at the edge where it is taken. An
  // optional idle gap with tvalid low may come first; without a gap tvalid
  // simply stays high, so it gets a single assignment in each time step.
  task automatic send_beat(input bit src, input bit blk_end);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, src};
    s_axis_tlast  <= blk_end;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_source_beat(src, blk_end);
  endtask

  // Ends a phase: input goes quiet, every predicted beat must come out, and
  // the block is left quiet to settle before the configuration may change.
  task automatic drain_and_settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Output side: checks every beat taken at a rising edge and throttles tready
  // with random stall bursts, starting a burst only after a ready cycle.
  // Signals are read right at the edge, before any update of that step.
  initial begin
    rsc_pkg::result_t beat;
    m_axis_tready = 1'b0;
    stall_left    = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        beat.sys_bit     = m_axis_tdata[0];
        beat.parity_bits = m_axis_tdata[4:1];
        beat.is_tail     = m_axis_tuser;
        beat.last        = m_axis_tlast;
        sb.check_coded_beat(beat);
      end
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_idle_on && m_axis_tready && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 5);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: any cycle that moves a beat on either side restarts the count.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [rsc_pkg::CL_W-1:0]    cl_val;
    logic [rsc_pkg::NP_W-1:0]    np_val;
    logic [rsc_pkg::POLYS_W-1:0] polys_val;
    int unsigned                 beats_in_phase;
    bit                          blk_end;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = rsc_pkg::CFG_CODE_LEN;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    src_idle_on   = 1'b1;
    sink_idle_on  = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: all generator masks are zero, so only the
    // systematic bit and the two tail beats of a length-three code show.
    send_beat(1'b1, 1'b0);
    send_beat(1'b0, 1'b1);
    drain_and_settle();

    // Longest code, all four generators, every mask bit set. One terminated
    // block with eight tail beats, then a block left open so the register
    // holds eight live bits across the next configuration change.
    program_encoder(4'd9, 3'd4, 9'h1FF, 36'hF_FFFF_FFFF, 1'b1, 1'b1);
    send_beat(1'b1, 1'b0);
    send_beat(1'b1, 1'b0);
    send_beat(1'b0, 1'b1);
    send_beat(1'b1, 1'b0);
    send_beat(1'b1, 1'b0);
    send_beat(1'b1, 1'b0);
    drain_and_settle();

    // Constraint length shrinks in the middle of a block: the held register
    // must be cut down to the new depth before it is used.
    program_encoder(4'd4, 3'd3, 9'h0A5, 36'h1B3_0C6_155, 1'b1, 1'b1);
    send_beat(1'b0, 1'b0);
    send_beat(1'b1, 1'b1);
    drain_and_settle();

    // Shortest code with termination and the systematic bit both off: a
    // block end gives a single beat marked last, and the state still clears.
    program_encoder(4'd2, 3'd1, 9'h001, 36'h0_0000_0003, 1'b0, 1'b0);
    send_beat(1'b1, 1'b0);
    send_beat(1'b1, 1'b1);
    send_beat(1'b0, 1'b0);
    send_beat(1'b1, 1'b0);
    drain_and_settle();

    // Out-of-range counts clamp upward: constraint length and parity count
    // of zero act as the minimums. Feedback mask zero is a feedforward code.
    program_encoder(4'd0, 3'd0, 9'h000, 36'h5_A3C9_6F1E, 1'b1, 1'b1);
    send_beat(1'b1, 1'b0);
    send_beat(1'b1, 1'b1);
    drain_and_settle();

    // Values above the maximums clamp downward; only the feedback mask's top
    // bit is set, and it lies past the register, so the code is feedforward.
    // Writes to indexes past the register list must leave everything alone.
    program_encoder(4'd15, 3'd7, 9'h100, 36'hA_5A5A_5A5A, 1'b1, 1'b1);
    write_reg(CFG_SPARE_LO, '1);
    write_reg(CFG_SPARE_HI, '1);
    send_beat(1'b1, 1'b0);
    send_beat(1'b0, 1'b0);
    send_beat(1'b1, 1'b1);
    drain_and_settle();

    // Random phases: fresh configuration each time, mostly legal lengths and
    // counts with an occasional out-of-range value. Blocks of random length
    // and content; a phase sometimes stops mid-block so the next length
    // change meets a live register. The last two phases run without idling.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      cl_val = ($urandom_range(0, 7) == 0) ? rsc_pkg::CL_W'($urandom_range(0, 15))
                                           : rsc_pkg::CL_W'($urandom_range(2, 9));
      np_val = ($urandom_range(0, 7) == 0) ? rsc_pkg::NP_W'($urandom_range(0, 7))
                                           : rsc_pkg::NP_W'($urandom_range(1, 4));
      polys_val = rsc_pkg::POLYS_W'({$urandom(), $urandom()});
      program_encoder(cl_val, np_val, rsc_pkg::POLY_W'($urandom()), polys_val,
                      1'($urandom_range(0, 3) != 0), 1'($urandom_range(0, 1)));
      if (ph >= RANDOM_PHASES - 2) begin
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
      end else begin
        src_idle_on  = 1'($urandom_range(0, 3) != 0);
        sink_idle_on = 1'($urandom_range(0, 3) != 0);
      end
      beats_in_phase = $urandom_range(8, 16);
      for (int k = 0; k < beats_in_phase; k++) begin
        if (k == beats_in_phase - 1) begin
          blk_end = ($urandom_range(0, 3) != 0);
        end else begin
          blk_end = ($urandom_range(0, 5) == 0);
        end
        send_beat(1'($urandom_range(0, 1)), blk_end);
      end
      drain_and_settle();
    end

    // Watch a while longer for beats that should not exist, then report.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
